// File: design/cst_pkg.sv
package cst_pkg;

  localparam int RESULT_WIDTH = 48;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 33;
  localparam int DM_W    = 32;
  localparam int TK_W    = 31;
  localparam int AREA_W  = 31;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_D11   = 3'd0;
  localparam logic [2:0] REG_D12   = 3'd1;
  localparam logic [2:0] REG_D13   = 3'd2;
  localparam logic [2:0] REG_D22   = 3'd3;
  localparam logic [2:0] REG_D23   = 3'd4;
  localparam logic [2:0] REG_D33   = 3'd5;
  localparam logic [2:0] REG_THICK = 3'd6;
  localparam logic [2:0] REG_AREA  = 3'd7;

  localparam logic [DM_W-1:0]   D11_RST   = 32'd64000000;
  localparam logic [DM_W-1:0]   D12_RST   = 32'd25600000;
  localparam logic [DM_W-1:0]   D13_RST   = 32'd0;
  localparam logic [DM_W-1:0]   D22_RST   = 32'd64000000;
  localparam logic [DM_W-1:0]   D23_RST   = 32'd0;
  localparam logic [DM_W-1:0]   D33_RST   = 32'd19200000;
  localparam logic [TK_W-1:0]   THICK_RST = 31'd6554;
  localparam logic [AREA_W-1:0] AREA_RST  = 31'd335544;

  // Row and column index of the final entry of an element.
  localparam logic [2:0] LAST_IDX = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Radix-4 divider: 64 quotient bits in 32 steps, one lane per entry in flight.
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int DIV_LANES  = DIV_STEPS + 1;
  localparam int LANE_PTR_W = $clog2(DIV_LANES);

  typedef struct packed {
    logic [15:0]              element_index;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    logic signed [COORD_W-1:0] x_c;
    logic signed [COORD_W-1:0] y_c;
  } in_item_t;

  typedef struct packed {
    logic [15:0]                   element_tag;
    logic [2:0]                    row_index;
    logic [2:0]                    col_index;
    logic signed [RESULT_WIDTH-1:0] stiffness_value;
    logic                          saturated;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    logic [15:0]             tag;
    logic [2:0][COEF_W-1:0]  b;
    logic [2:0][COEF_W-1:0]  c;
  } coef_item_t;

  typedef struct packed {
    logic [DM_W-1:0]   d_11;
    logic [DM_W-1:0]   d_12;
    logic [DM_W-1:0]   d_13;
    logic [DM_W-1:0]   d_22;
    logic [DM_W-1:0]   d_23;
    logic [DM_W-1:0]   d_33;
    logic [TK_W-1:0]   thickness;
    logic [AREA_W-1:0] element_area;
  } cfg_regs_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
    logic        neg;
    logic        pre;
    logic        pre_lim;
    logic [31:0] rem;
    logic [63:0] quo;
  } disp_t;

endpackage

// File: design/cst_front.sv
module cst_front
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       f_valid,
  output coef_item_t f_item,
  input  logic       f_ready
);

  logic       f_valid_r;
  coef_item_t f_item_r;
  coef_item_t f_item_nxt;

  function automatic logic [COEF_W-1:0] diff33(logic [COORD_W-1:0] p, logic [COORD_W-1:0] q);
    return {p[COORD_W-1], p} - {q[COORD_W-1], q};
  endfunction

  // b_i = y_j - y_k, c_i = x_k - x_j with (i, j, k) cycling over the vertices.
  always_comb begin
    f_item_nxt.tag  = in_data.element_index;
    f_item_nxt.b[0] = diff33(in_data.y_b, in_data.y_c);
    f_item_nxt.c[0] = diff33(in_data.x_c, in_data.x_b);
    f_item_nxt.b[1] = diff33(in_data.y_c, in_data.y_a);
    f_item_nxt.c[1] = diff33(in_data.x_a, in_data.x_c);
    f_item_nxt.b[2] = diff33(in_data.y_a, in_data.y_b);
    f_item_nxt.c[2] = diff33(in_data.x_b, in_data.x_a);
  end

  assign in_ready = !f_valid_r || f_ready;
  assign f_valid  = f_valid_r;
  assign f_item   = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// File: design/cst_queue.sv
module cst_queue
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  coef_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output coef_item_t pop_item
);

  coef_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/cst_back.sv
module cst_back
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       q_valid,
  input  coef_item_t q_item,
  output logic       q_pop,
  output logic       disp_valid,
  output disp_t      disp,
  input  logic       disp_ready
);

  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } ent_t;

  logic [2:0] row_r;
  logic [2:0] col_r;
  logic [7:0] v_r;
  logic       adv;
  logic       issue;

  // Stage 1 selection.
  logic [1:0]        vm, vn;
  logic              am, an;
  logic [COEF_W-1:0] top_m, r2_m, top_n, r2_n;
  logic [DM_W-1:0]   d_tt, d_t2, d_2t;
  ent_t              ent_s0;

  ent_t               s1_e_r, s2_e_r, s3_e_r, s4_e_r, s5_e_r, s6_e_r, s7_e_r;
  logic signed [64:0] s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r;
  logic [COEF_W-1:0]  s1_ut_r, s1_u2_r, s2_ut_r, s2_u2_r;
  logic signed [65:0] s2_gt_r, s2_g2_r;
  logic signed [66:0] s3_lt_r, s3_l2_r;
  logic signed [65:0] s3_ht_r, s3_h2_r;
  logic [99:0]        s4_s_r;
  logic [99:0]        mag100;
  logic               s5_neg_r, s6_neg_r, s7_neg_r;
  logic [98:0]        s5_mag_r;
  logic [62:0]        s6_pp0_r, s6_pp1_r, s6_pp2_r;
  logic [33:0]        s6_pp3_r;
  logic [129:0]       s7_n_r;
  disp_t              s8_r;
  disp_t              s8_nxt;

  logic        area_zero, n_zero, big;
  logic [95:0] m_val;

  assign adv        = !(v_r[7] && !disp_ready);
  assign issue      = adv && q_valid;
  assign q_pop      = issue && (row_r == LAST_IDX) && (col_r == LAST_IDX);
  assign disp_valid = v_r[7];
  assign disp       = s8_r;

  // Column m of B holds two non-zero values: one in row 0 or 1 by axis, one in row 2.
  always_comb begin
    vm    = row_r[2:1];
    am    = row_r[0];
    vn    = col_r[2:1];
    an    = col_r[0];
    top_m = am ? q_item.c[vm] : q_item.b[vm];
    r2_m  = am ? q_item.b[vm] : q_item.c[vm];
    top_n = an ? q_item.c[vn] : q_item.b[vn];
    r2_n  = an ? q_item.b[vn] : q_item.c[vn];
    if (!am && !an) begin
      d_tt = cfg.d_11;
    end else if (am && an) begin
      d_tt = cfg.d_22;
    end else begin
      d_tt = cfg.d_12;
    end
    d_t2        = am ? cfg.d_23 : cfg.d_13;
    d_2t        = an ? cfg.d_23 : cfg.d_13;
    ent_s0.tag  = q_item.tag;
    ent_s0.row  = row_r;
    ent_s0.col  = col_r;
    ent_s0.last = (row_r == LAST_IDX) && (col_r == LAST_IDX);
  end

  always_comb begin
    mag100 = s4_s_r[99] ? (~s4_s_r + 100'd1) : s4_s_r;
  end

  // Rounded division is rebased on 2*area: round(N / (area*2^18)) equals
  // floor((2*floor(N/2^18) + N[17] + area) / (2*area)).
  always_comb begin
    area_zero      = (cfg.element_area == '0);
    n_zero         = (s7_n_r == '0);
    big            = (s7_n_r[129:80] >= {19'd0, cfg.element_area});
    m_val          = {1'b0, s7_n_r[111:18], s7_n_r[17]} + {65'd0, cfg.element_area};
    s8_nxt.tag     = s7_e_r.tag;
    s8_nxt.row     = s7_e_r.row;
    s8_nxt.col     = s7_e_r.col;
    s8_nxt.last    = s7_e_r.last;
    s8_nxt.neg     = s7_neg_r && !(area_zero && n_zero);
    s8_nxt.pre     = area_zero || big;
    s8_nxt.pre_lim = !area_zero || !n_zero;
    s8_nxt.rem     = m_val[95:64];
    s8_nxt.quo     = m_val[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      v_r   <= '0;
    end else if (adv) begin
      v_r <= {v_r[6:0], issue};
      if (issue) begin
        if (col_r == LAST_IDX) begin
          col_r <= '0;
          row_r <= (row_r == LAST_IDX) ? '0 : row_r + 3'd1;
        end else begin
          col_r <= col_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e_r   <= ent_s0;
      s1_p0_r  <= $signed(top_m) * $signed(d_tt);
      s1_p1_r  <= $signed(r2_m) * $signed(d_2t);
      s1_p2_r  <= $signed(top_m) * $signed(d_t2);
      s1_p3_r  <= $signed(r2_m) * $signed(cfg.d_33);
      s1_ut_r  <= top_n;
      s1_u2_r  <= r2_n;

      s2_e_r   <= s1_e_r;
      s2_gt_r  <= s1_p0_r + s1_p1_r;
      s2_g2_r  <= s1_p2_r + s1_p3_r;
      s2_ut_r  <= s1_ut_r;
      s2_u2_r  <= s1_u2_r;

      s3_e_r   <= s2_e_r;
      s3_lt_r  <= $signed({1'b0, s2_gt_r[32:0]}) * $signed(s2_ut_r);
      s3_ht_r  <= $signed(s2_gt_r[65:33]) * $signed(s2_ut_r);
      s3_l2_r  <= $signed({1'b0, s2_g2_r[32:0]}) * $signed(s2_u2_r);
      s3_h2_r  <= $signed(s2_g2_r[65:33]) * $signed(s2_u2_r);

      s4_e_r   <= s3_e_r;
      s4_s_r   <= ({{34{s3_ht_r[65]}}, s3_ht_r} << 33) + {{33{s3_lt_r[66]}}, s3_lt_r}
                + ({{34{s3_h2_r[65]}}, s3_h2_r} << 33) + {{33{s3_l2_r[66]}}, s3_l2_r};

      s5_e_r   <= s4_e_r;
      s5_neg_r <= s4_s_r[99];
      s5_mag_r <= mag100[98:0];

      s6_e_r   <= s5_e_r;
      s6_neg_r <= s5_neg_r;
      s6_pp0_r <= s5_mag_r[31:0] * cfg.thickness;
      s6_pp1_r <= s5_mag_r[63:32] * cfg.thickness;
      s6_pp2_r <= s5_mag_r[95:64] * cfg.thickness;
      s6_pp3_r <= s5_mag_r[98:96] * cfg.thickness;

      s7_e_r   <= s6_e_r;
      s7_neg_r <= s6_neg_r;
      s7_n_r   <= {67'd0, s6_pp0_r} + {35'd0, s6_pp1_r, 32'd0}
                + {3'd0, s6_pp2_r, 64'd0} + {s6_pp3_r, 96'd0};

      s8_r     <= s8_nxt;
    end
  end

  // A stalled hand-over to the divider freezes every stage behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[7] && !disp_ready) |=> ($stable(v_r) && $stable(row_r) && $stable(col_r)))
    else $error("back pipeline moved while the divider hand-over was stalled");

endmodule

// File: design/cst_div_pool.sv
module cst_div_pool
  import cst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [AREA_W-1:0] area,
  input  logic              disp_valid,
  input  disp_t             disp,
  output logic              disp_ready,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              out_ready
);

  localparam logic [1:0] LN_IDLE = 2'd0;
  localparam logic [1:0] LN_RUN  = 2'd1;
  localparam logic [1:0] LN_DONE = 2'd2;

  logic [1:0]           st_r  [DIV_LANES];
  logic [DIV_CNT_W-1:0] cnt_r [DIV_LANES];
  disp_t                dat_r [DIV_LANES];
  logic [31:0]          step_rem [DIV_LANES];
  logic [63:0]          step_quo [DIV_LANES];

  logic [LANE_PTR_W-1:0] rd_ptr_r;
  logic [LANE_PTR_W-1:0] wr_ptr_r;
  logic                  out_valid_r;
  out_item_t             out_r;
  out_item_t             out_nxt;
  logic                  retire;
  logic                  disp_fire;

  logic [33:0] dv1, dv2, dv3;
  disp_t       sel;
  logic [63:0] lim;
  logic [63:0] mag;
  logic [63:0] val;
  logic        over;

  assign dv1 = {2'b00, area, 1'b0};
  assign dv2 = {1'b0, area, 2'b00};
  assign dv3 = dv1 + dv2;

  // One radix-4 digit per lane and cycle; the remainder stays below 2*area.
  always_comb begin
    logic [33:0] t;
    logic [33:0] sub;
    logic [1:0]  dig;
    for (int i = 0; i < DIV_LANES; i++) begin
      t = {dat_r[i].rem, dat_r[i].quo[63:62]};
      if (t >= dv3) begin
        dig = 2'd3;
        sub = dv3;
      end else if (t >= dv2) begin
        dig = 2'd2;
        sub = dv2;
      end else if (t >= dv1) begin
        dig = 2'd1;
        sub = dv1;
      end else begin
        dig = 2'd0;
        sub = '0;
      end
      step_rem[i] = 32'(t - sub);
      step_quo[i] = {dat_r[i].quo[61:0], dig};
    end
  end

  assign retire     = (st_r[rd_ptr_r] == LN_DONE) && (!out_valid_r || out_ready);
  assign disp_ready = (st_r[wr_ptr_r] == LN_IDLE) || (retire && (rd_ptr_r == wr_ptr_r));
  assign disp_fire  = disp_valid && disp_ready;

  always_comb begin
    sel  = dat_r[rd_ptr_r];
    lim  = {{(64 - RESULT_WIDTH + 1){1'b0}}, {(RESULT_WIDTH - 1){1'b1}}} + {63'd0, sel.neg};
    over = (sel.quo > lim);
    if (sel.pre) begin
      mag = sel.pre_lim ? lim : '0;
    end else begin
      mag = over ? lim : sel.quo;
    end
    val                     = sel.neg ? (~mag + 64'd1) : mag;
    out_nxt.element_tag     = sel.tag;
    out_nxt.row_index       = sel.row;
    out_nxt.col_index       = sel.col;
    out_nxt.stiffness_value = val[RESULT_WIDTH-1:0];
    out_nxt.saturated       = sel.pre || over;
    out_nxt.last            = sel.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_LANES; i++) begin
        st_r[i]  <= LN_IDLE;
        cnt_r[i] <= '0;
      end
    end else begin
      if (retire) begin
        out_valid_r <= 1'b1;
        rd_ptr_r    <= (rd_ptr_r == LANE_PTR_W'(DIV_LANES - 1)) ? '0 : rd_ptr_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (disp_fire) begin
        wr_ptr_r <= (wr_ptr_r == LANE_PTR_W'(DIV_LANES - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      for (int i = 0; i < DIV_LANES; i++) begin
        if (disp_fire && (wr_ptr_r == LANE_PTR_W'(i))) begin
          st_r[i]  <= disp.pre ? LN_DONE : LN_RUN;
          cnt_r[i] <= '0;
        end else if (retire && (rd_ptr_r == LANE_PTR_W'(i))) begin
          st_r[i] <= LN_IDLE;
        end else if (st_r[i] == LN_RUN) begin
          cnt_r[i] <= cnt_r[i] + 1'b1;
          if (cnt_r[i] == DIV_CNT_W'(DIV_STEPS - 1)) begin
            st_r[i] <= LN_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_r <= out_nxt;
    end
    for (int i = 0; i < DIV_LANES; i++) begin
      if (disp_fire && (wr_ptr_r == LANE_PTR_W'(i))) begin
        dat_r[i] <= disp;
      end else if (st_r[i] == LN_RUN) begin
        dat_r[i].rem <= step_rem[i];
        dat_r[i].quo <= step_quo[i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |->
      (out_r.row_index == LAST_IDX && out_r.col_index == LAST_IDX))
    else $error("last flag on an entry other than row 5 col 5");

  // Lanes are filled and drained in turn: an idle oldest lane means an empty pool.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r[rd_ptr_r] == LN_IDLE) |-> (rd_ptr_r == wr_ptr_r))
    else $error("divider lanes out of order");

  assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r < LANE_PTR_W'(DIV_LANES)) && (wr_ptr_r < LANE_PTR_W'(DIV_LANES)))
    else $error("lane pointer beyond the lane count");

endmodule

// File: design/cst_element_stiffness.sv
// Constant-strain triangle element stiffness. Each input transaction carries one
// triangle (index and three Q16.16 vertices); the block answers with the 36 entries of
// t/(4A) * B^T D B in row-major order, Q32.16, rounded to nearest (ties away from zero)
// and saturated, the last entry flagged. D, thickness and area come from the APB
// registers and are to be written only while the block is idle; a zero area sets the
// saturated flag on every entry and clips every non-zero one. While out_ready is held,
// the sustained rate is one result entry per clock, set by the single result channel.
// The first entry's out_valid rises after the front register, the queue, the eight
// multiply pipeline stages, the hand-over into a divider lane, 32 radix-4 steps in
// that lane and the output register. A pool of 33 lanes keeps the rate at one entry
// per clock while out_ready is held, and entries leave the pool in order. No clearing
// pass follows reset.
module cst_element_stiffness
  import cst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_regs_t  cfg_r;
  logic       cfg_wr;
  logic       f_valid;
  logic       f_ready;
  coef_item_t f_item;
  logic       q_valid;
  logic       q_pop;
  coef_item_t q_item;
  logic       disp_valid;
  logic       disp_ready;
  disp_t      disp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.d_11         <= D11_RST;
      cfg_r.d_12         <= D12_RST;
      cfg_r.d_13         <= D13_RST;
      cfg_r.d_22         <= D22_RST;
      cfg_r.d_23         <= D23_RST;
      cfg_r.d_33         <= D33_RST;
      cfg_r.thickness    <= THICK_RST;
      cfg_r.element_area <= AREA_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_D11:   cfg_r.d_11         <= cfg_pwdata;
        REG_D12:   cfg_r.d_12         <= cfg_pwdata;
        REG_D13:   cfg_r.d_13         <= cfg_pwdata;
        REG_D22:   cfg_r.d_22         <= cfg_pwdata;
        REG_D23:   cfg_r.d_23         <= cfg_pwdata;
        REG_D33:   cfg_r.d_33         <= cfg_pwdata;
        REG_THICK: cfg_r.thickness    <= cfg_pwdata[TK_W-1:0];
        REG_AREA:  cfg_r.element_area <= cfg_pwdata[AREA_W-1:0];
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[4:2])
        REG_D11:   cfg_prdata = cfg_r.d_11;
        REG_D12:   cfg_prdata = cfg_r.d_12;
        REG_D13:   cfg_prdata = cfg_r.d_13;
        REG_D22:   cfg_prdata = cfg_r.d_22;
        REG_D23:   cfg_prdata = cfg_r.d_23;
        REG_D33:   cfg_prdata = cfg_r.d_33;
        REG_THICK: cfg_prdata = {1'b0, cfg_r.thickness};
        REG_AREA:  cfg_prdata = {1'b0, cfg_r.element_area};
      endcase
    end
  end

  cst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_item   (f_item),
    .f_ready  (f_ready)
  );

  cst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  cst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .disp_valid (disp_valid),
    .disp       (disp),
    .disp_ready (disp_ready)
  );

  cst_div_pool u_div_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .area       (cfg_r.element_area),
    .disp_valid (disp_valid),
    .disp       (disp),
    .disp_ready (disp_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cst_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  cst_element_stiffness DUT (.*);

  // Working copy of the register file.
  logic [31:0] mat_reg [6];
  logic [30:0] thick_reg;
  logic [30:0] area_reg;

  in_item_t  pending_elems [$];
  out_item_t stiffness_exp [$];
  bit        failed;
  bit        in_taken;
  bit        send_hold;
  bit        stall_req;
  int        burst_left;
  int        gap_left;
  int        stall_cnt;
  int        ready_mode;
  int        mode_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void queue_elem(in_item_t el);
    pending_elems = {pending_elems, el};
  endfunction

  // Expected 36 stiffness entries of one element, computed exactly in wide integers.
  function automatic void predict_stiffness(in_item_t el);
    logic signed [159:0] xs [3];
    logic signed [159:0] ys [3];
    logic signed [159:0] bmat [3][6];
    logic signed [159:0] dmat [3][3];
    logic signed [159:0] acc;
    logic [159:0]        mag_w;
    logic [159:0]        divisor;
    logic [159:0]        quo_w;
    logic [159:0]        rem_w;
    logic [63:0]         lim;
    logic [63:0]         mag;
    logic                negative;
    logic                sat;
    int                  j;
    int                  k;
    out_item_t           r;
    xs[0] = el.x_a; ys[0] = el.y_a;
    xs[1] = el.x_b; ys[1] = el.y_b;
    xs[2] = el.x_c; ys[2] = el.y_c;
    dmat[0][0] = $signed(mat_reg[REG_D11]);
    dmat[0][1] = $signed(mat_reg[REG_D12]);
    dmat[1][0] = dmat[0][1];
    dmat[0][2] = $signed(mat_reg[REG_D13]);
    dmat[2][0] = dmat[0][2];
    dmat[1][1] = $signed(mat_reg[REG_D22]);
    dmat[1][2] = $signed(mat_reg[REG_D23]);
    dmat[2][1] = dmat[1][2];
    dmat[2][2] = $signed(mat_reg[REG_D33]);
    for (int v = 0; v < 3; v++) begin
      j = (v + 1) % 3;
      k = (v + 2) % 3;
      bmat[0][2*v] = ys[j] - ys[k];
      bmat[0][2*v+1] = '0;
      bmat[1][2*v] = '0;
      bmat[1][2*v+1] = xs[k] - xs[j];
      bmat[2][2*v] = xs[k] - xs[j];
      bmat[2][2*v+1] = ys[j] - ys[k];
    end
    divisor = 160'(area_reg) << 18;
    for (int m = 0; m < 6; m++) begin
      for (int n = 0; n < 6; n++) begin
        acc = '0;
        for (int p = 0; p < 3; p++)
          for (int q = 0; q < 3; q++)
            acc = acc + bmat[p][m] * dmat[p][q] * bmat[q][n];
        negative = acc[159];
        mag_w = negative ? -acc : acc;
        mag_w = mag_w * 160'(thick_reg);
        lim = negative ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        sat = 1'b0;
        mag = '0;
        if (divisor == 0) begin
          sat = 1'b1;
          if (mag_w == 0)
            negative = 1'b0;
          else
            mag = lim;
        end else begin
          quo_w = mag_w / divisor;
          rem_w = mag_w % divisor;
          if (quo_w >= (160'd1 << 62)) begin
            sat = 1'b1;
            mag = lim;
          end else begin
            mag = quo_w[63:0] + ((rem_w << 1) >= divisor ? 64'd1 : 64'd0);
            if (mag > lim) begin
              sat = 1'b1;
              mag = lim;
            end
          end
        end
        r.element_tag = el.element_index;
        r.row_index = 3'(m);
        r.col_index = 3'(n);
        r.stiffness_value = negative ? -mag[RESULT_WIDTH-1:0] : mag[RESULT_WIDTH-1:0];
        r.saturated = sat;
        r.last = (m == 5 && n == 5);
        stiffness_exp = {stiffness_exp, r};
      end
    end
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_THICK)
      thick_reg = value[30:0];
    else if (idx == REG_AREA)
      area_reg = value[30:0];
    else
      mat_reg[idx] = value;
  endtask

  task automatic write_material(logic [31:0] d11, logic [31:0] d12, logic [31:0] d13,
                                logic [31:0] d22, logic [31:0] d23, logic [31:0] d33,
                                logic [31:0] tk, logic [31:0] ar);
    reg_write(REG_D11, d11);
    reg_write(REG_D12, d12);
    reg_write(REG_D13, d13);
    reg_write(REG_D22, d22);
    reg_write(REG_D23, d23);
    reg_write(REG_D33, d33);
    reg_write(REG_THICK, tk);
    reg_write(REG_AREA, ar);
  endtask

  task automatic wait_idle();
    while (pending_elems.size() != 0 || in_valid || stiffness_exp.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic in_item_t make_elem(logic [15:0] idx, logic [31:0] xa, logic [31:0] ya,
                                         logic [31:0] xb, logic [31:0] yb,
                                         logic [31:0] xc, logic [31:0] yc);
    in_item_t el;
    el.element_index = idx;
    el.x_a = xa; el.y_a = ya;
    el.x_b = xb; el.y_b = yb;
    el.x_c = xc; el.y_c = yc;
    return el;
  endfunction

  // Mostly mesh-like triangles of modest size, with some full-range coordinates.
  function automatic in_item_t random_elem();
    in_item_t el;
    logic [31:0] span;
    el.element_index = 16'($urandom);
    span = 32'd1 << $urandom_range(4, 22);
    if ($urandom_range(0, 4) == 0) begin
      el.x_a = $urandom; el.y_a = $urandom;
      el.x_b = $urandom; el.y_b = $urandom;
      el.x_c = $urandom; el.y_c = $urandom;
    end else begin
      el.x_a = $urandom;
      el.y_a = $urandom;
      el.x_b = el.x_a + $signed($urandom_range(0, span)) - $signed(span >> 1);
      el.y_b = el.y_a + $signed($urandom_range(0, span)) - $signed(span >> 1);
      el.x_c = el.x_a + $signed($urandom_range(0, span)) - $signed(span >> 1);
      el.y_c = el.y_a + $signed($urandom_range(0, span)) - $signed(span >> 1);
    end
    return el;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_elems.size() != 0 && !send_hold) begin
        in_data <= pending_elems.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req = 1'b0;
      stall_cnt = 400;
    end
    if (mode_cnt == 0) begin
      mode_cnt = $urandom_range(50, 300);
      ready_mode = $urandom_range(0, 3);
    end
    mode_cnt--;
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // Monitor: predict on each accepted element, check each accepted entry.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        predict_stiffness(in_data);
      end
      if (out_valid && out_ready) begin
        if (stiffness_exp.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected entry %p", $time, out_data);
        end else begin
          want = stiffness_exp.pop_front();
          if (out_data.element_tag !== want.element_tag) begin
            failed = 1'b1;
            $display("%0t: element_tag expected %0d got %0d", $time,
                     want.element_tag, out_data.element_tag);
          end
          if (out_data.row_index !== want.row_index) begin
            failed = 1'b1;
            $display("%0t: row_index expected %0d got %0d", $time,
                     want.row_index, out_data.row_index);
          end
          if (out_data.col_index !== want.col_index) begin
            failed = 1'b1;
            $display("%0t: col_index expected %0d got %0d", $time,
                     want.col_index, out_data.col_index);
          end
          if (out_data.stiffness_value !== want.stiffness_value) begin
            failed = 1'b1;
            $display("%0t: stiffness_value (%0d,%0d) expected %0d got %0d", $time,
                     want.row_index, want.col_index, want.stiffness_value,
                     out_data.stiffness_value);
          end
          if (out_data.saturated !== want.saturated) begin
            failed = 1'b1;
            $display("%0t: saturated expected %0b got %0b", $time,
                     want.saturated, out_data.saturated);
          end
          if (out_data.last !== want.last) begin
            failed = 1'b1;
            $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    failed = 1'b0;
    in_taken = 1'b0;
    send_hold = 1'b0;
    stall_req = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_cnt = 0;
    mode_cnt = 0;
    mat_reg[REG_D11] = D11_RST;
    mat_reg[REG_D12] = D12_RST;
    mat_reg[REG_D13] = D13_RST;
    mat_reg[REG_D22] = D22_RST;
    mat_reg[REG_D23] = D23_RST;
    mat_reg[REG_D33] = D33_RST;
    thick_reg = THICK_RST;
    area_reg = AREA_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset material first: unit triangle, clockwise, collinear, zero and extreme vertices.
    queue_elem(make_elem(16'h0000, 32'h0, 32'h0, 32'h10000, 32'h0,
                         32'h0, 32'h10000));
    queue_elem(make_elem(16'hFFFF, 32'h0, 32'h0, 32'h0, 32'h10000,
                         32'h10000, 32'h0));
    queue_elem(make_elem(16'h5A5A, 32'h0, 32'h0, 32'h10000, 32'h10000,
                         32'h20000, 32'h20000));
    queue_elem(make_elem(16'h0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    queue_elem(make_elem(16'hA5A5, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    queue_elem(make_elem(16'h8000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                         32'h80000000, 32'h80000000, 32'h7FFFFFFF));
    queue_elem(make_elem(16'h7FFF, 32'hFFFFFFFF, 32'h1, 32'h1, 32'hFFFFFFFF,
                         32'h0, 32'h0));
    wait_idle();

    // Extreme material, tiny area: saturation in both directions.
    write_material(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'hFFFFFFFF, 32'h1);
    queue_elem(make_elem(16'h0002, 32'h0, 32'h0, 32'h10000, 32'h0,
                         32'h0, 32'h10000));
    queue_elem(make_elem(16'h0003, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                         32'h7FFFFFFF, 32'h0, 32'h0));
    queue_elem(make_elem(16'h0004, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0));
    wait_idle();

    // Zero area: every non-zero entry saturates, zero entries stay zero.
    write_material(32'd64000000, 32'hFF000000, 32'd0, 32'd64000000, 32'd5, 32'd19200000,
                   32'd6554, 32'h80000000);
    queue_elem(make_elem(16'h0005, 32'h0, 32'h0, 32'h10000, 32'h0,
                         32'h0, 32'h10000));
    queue_elem(make_elem(16'h0006, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    queue_elem(random_elem());
    wait_idle();

    // Zero thickness with zero area, then the largest area with the largest thickness.
    reg_write(REG_THICK, 32'h0);
    queue_elem(make_elem(16'h0007, 32'h0, 32'h0, 32'h10000, 32'h0,
                         32'h0, 32'h10000));
    wait_idle();
    reg_write(REG_THICK, 32'h7FFFFFFF);
    reg_write(REG_AREA, 32'h7FFFFFFF);
    queue_elem(make_elem(16'h0008, 32'h0, 32'h0, 32'h10000, 32'h0,
                         32'h0, 32'h10000));
    queue_elem(make_elem(16'h0009, 32'h80000000, 32'h0, 32'h7FFFFFFF,
                         32'h80000000, 32'h0, 32'h7FFFFFFF));
    wait_idle();

    // Random phases; one fills the block behind a long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_material(D11_RST, D12_RST, D13_RST, D22_RST, D23_RST, D33_RST,
                       THICK_RST, AREA_RST);
      end else begin
        write_material($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 20),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 16, 1 << 26));
      end
      if (ph == 2)
        stall_req = 1'b1;
      for (int i = 0; i < 78; i++)
        queue_elem(random_elem());
      if (ph == 4) begin
        // Hold the sender until the block has drained completely.
        while (pending_elems.size() > 40)
          @(posedge clk);
        send_hold = 1'b1;
        while (in_valid || stiffness_exp.size() != 0)
          @(posedge clk);
        send_hold = 1'b0;
      end
      wait_idle();
    end

    if (failed) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

endmodule
